[hw/rtl/stls_pkg.sv]
// ----------------------------------------------------------------------------
// stls_pkg: shared types and helpers for the sorted-table lower-bound search
// Table geometry, the item record that travels down the pipeline and the
// per-stage narrowing step.
// ----------------------------------------------------------------------------
package stls_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = 11;
  localparam int unsigned SlotW      = 10;
  localparam int unsigned KeyW       = 31;
  // Worst-case number of bisection steps after the end checks
  localparam int unsigned NumProbe   = $clog2(TableDepth);

  typedef enum logic {
    ActLoad  = 1'b0,
    ActQuery = 1'b1
  } action_e;

  // One request and its search window
  typedef struct packed {
    logic              query;
    logic [SlotW-1:0]  slot;
    logic [KeyW-1:0]   key;
    logic [AddrW-1:0]  left;
    logic [AddrW-1:0]  right;
    logic              done;
    logic [CountW-1:0] pos;
  } item_t;

  // Pipeline register contents: the request plus the table words it read
  typedef struct packed {
    item_t            item;
    logic             chk_bounds;
    logic             probe;
    logic [AddrW-1:0] mid;
    logic [KeyW-1:0]  rd_lo;
    logic [KeyW-1:0]  rd_hi;
  } stage_t;

  // Apply the compare against the words read in the previous stage
  function automatic item_t resolve(input stage_t s);
    item_t r;
    r = s.item;
    if (s.chk_bounds) begin
      if (s.item.key <= s.rd_lo) begin
        r.done = 1'b1;
        r.pos  = '0;
      end else if (s.item.key > s.rd_hi) begin
        r.done = 1'b1;
        r.pos  = CountW'(s.item.right) + CountW'(1);
      end
    end else if (s.probe) begin
      if (s.item.key <= s.rd_lo) begin
        r.right = s.mid;
      end else begin
        r.left = s.mid;
      end
    end
    return r;
  endfunction

  // Slot lies inside the table
  function automatic logic slot_ok(input logic [SlotW-1:0] slot);
    return 32'(slot) < TableDepth;
  endfunction

endpackage

[hw/rtl/stls_head.sv]
// ----------------------------------------------------------------------------
// stls_head: entry stage of the lower-bound pipeline
// Registers the request, reads the first and last table entries in use and
// stores loads into its own copy of the table.
// ----------------------------------------------------------------------------
module stls_head import stls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic              action_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [CountW-1:0] count_i,
  output logic              valid_o,
  output stage_t            stage_o
);

  logic [KeyW-1:0]   table_q [TableDepth];
  logic [CountW-1:0] cnt_sat;
  logic              empty;
  logic              is_query;
  logic [AddrW-1:0]  last_idx;
  logic              valid_q;
  stage_t            stage_q;
  stage_t            stage_d;

  assign cnt_sat  = (count_i > CountW'(TableDepth)) ? CountW'(TableDepth) : count_i;
  assign empty    = (cnt_sat == '0);
  assign is_query = (action_i == ActQuery);
  assign last_idx = AddrW'(cnt_sat - CountW'(1));

  always_comb begin
    stage_d            = '0;
    stage_d.item.query = is_query;
    stage_d.item.slot  = slot_i;
    stage_d.item.key   = key_i;
    stage_d.item.left  = '0;
    stage_d.item.right = last_idx;
    stage_d.item.done  = empty;
    stage_d.item.pos   = '0;
    stage_d.chk_bounds = is_query && !empty;
    stage_d.probe      = 1'b0;
    stage_d.mid        = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Store loads, read both ends of the table in use
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q.item       <= stage_d.item;
      stage_q.chk_bounds <= stage_d.chk_bounds;
      stage_q.probe      <= stage_d.probe;
      stage_q.mid        <= stage_d.mid;
      stage_q.rd_lo      <= table_q[0];
      stage_q.rd_hi      <= table_q[last_idx];
      if (valid_i && !is_query && slot_ok(slot_i)) begin
        table_q[AddrW'(slot_i)] <= key_i;
      end
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

`ifndef ASSERT_OFF
  a_load_no_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !stage_q.item.query |-> !stage_q.chk_bounds)
    else $error("load marked for bound check");
`endif

endmodule

[hw/rtl/stls_probe.sv]
// ----------------------------------------------------------------------------
// stls_probe: one bisection step of the lower-bound pipeline
// Narrows the window with the word read upstream, then reads the midpoint of
// the new window from its own copy of the table.
// ----------------------------------------------------------------------------
module stls_probe import stls_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   valid_i,
  input  stage_t stage_i,
  output logic   valid_o,
  output stage_t stage_o
);

  logic [KeyW-1:0]  table_q [TableDepth];
  item_t            it;
  logic [AddrW:0]   lp1;
  logic [AddrW:0]   sum;
  logic             probe;
  logic [AddrW-1:0] mid;
  logic             valid_q;
  stage_t           stage_q;

  assign it    = resolve(stage_i);
  assign lp1   = {1'b0, it.left} + (AddrW+1)'(1);
  assign sum   = {1'b0, it.left} + {1'b0, it.right};
  assign mid   = sum[AddrW:1];
  assign probe = it.query && !it.done && (lp1 < {1'b0, it.right});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Store loads, read the midpoint word
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q.item       <= it;
      stage_q.chk_bounds <= 1'b0;
      stage_q.probe      <= probe;
      stage_q.mid        <= mid;
      stage_q.rd_lo      <= table_q[mid];
      stage_q.rd_hi      <= '0;
      if (valid_i && !stage_i.item.query && slot_ok(stage_i.item.slot)) begin
        table_q[AddrW'(stage_i.item.slot)] <= stage_i.item.key;
      end
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

`ifndef ASSERT_OFF
  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && stage_q.probe |->
      (stage_q.mid > stage_q.item.left) && (stage_q.mid < stage_q.item.right))
    else $error("probe midpoint outside open window");

  a_probe_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && stage_q.probe |-> stage_q.item.query && !stage_q.item.done)
    else $error("probe issued for load or finished request");
`endif

endmodule

[hw/rtl/sorted_table_lower_bound.sv]
// ----------------------------------------------------------------------------
// sorted_table_lower_bound: pipelined lower-bound search over a sorted table
// Loads fill a table of ascending keys slot by slot; queries return the first
// slot in use whose key is at least the query key.
// ----------------------------------------------------------------------------
// One request enters per cycle while the pipeline advances. A query passes
// through these registers in order: the stage that reads the first and last
// entries in use, then one stage per bisection step, which reads a midpoint,
// then the output register, which holds its position. The stage count is
// set by the number of halvings needed to close a window of TableDepth
// entries. Every stage keeps its own copy of the table, and a load writes
// each copy as it passes that stage, so every query sees exactly the loads
// accepted before it. Loads give no result.
// When the output register is full and not taken, the whole pipeline holds
// and in_ready_o drops. The table has no reset: query only slots already
// loaded. entry_count may be written only while no request is in flight;
// values above the table depth are treated as the depth.
// ----------------------------------------------------------------------------
module sorted_table_lower_bound import stls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  // Request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [KeyW-1:0]   key_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] position_o
);

  logic [CountW-1:0] entry_count_q;
  logic              adv;
  logic              valid_s [NumProbe+1];
  stage_t            stage_s [NumProbe+1];
  item_t             last;
  logic [CountW-1:0] position_d;
  logic [CountW-1:0] position_q;
  logic              out_valid_q;

  // Entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // Advance the whole pipeline unless a result waits in the output register and is not taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  stls_head u_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .action_i(action_i),
    .slot_i  (slot_i),
    .key_i   (key_i),
    .count_i (entry_count_q),
    .valid_o (valid_s[0]),
    .stage_o (stage_s[0])
  );

  // One bisection step per stage
  for (genvar g = 0; g < NumProbe; g++) begin : g_probe
    stls_probe u_probe (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(valid_s[g]),
      .stage_i(stage_s[g]),
      .valid_o(valid_s[g+1]),
      .stage_o(stage_s[g+1])
    );
  end

  // Close the last step; an open window ends right after its left edge
  assign last       = resolve(stage_s[NumProbe]);
  assign position_d = last.done ? last.pos : (CountW'(last.left) + CountW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_s[NumProbe] && last.query;
    end
  end

  // Drop loads, hold the query result until taken
  always_ff @(posedge clk_i) begin
    if (adv) begin
      position_q <= position_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o <= CountW'(TableDepth))
    else $error("position beyond table depth");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && valid_s[NumProbe] && !stage_s[NumProbe].item.query |=> !out_valid_o)
    else $error("load produced a result");
`endif

endmodule
